// ----- sv/insertion_sort_engine_macros.svh -----
// assertion macros for the insertion sort engine
// no dependencies; included by the top level
`ifndef INSERTION_SORT_ENGINE_MACROS_SVH
`define INSERTION_SORT_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define ISE_ASSERT_IMPL(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("insertion sort engine assertion failed");
`define ISE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("insertion sort engine assertion failed");
`else
`define ISE_ASSERT_IMPL(lbl, clk, rst, prop)
`define ISE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- sv/ise_pkg.sv -----
// shared types for the insertion sort engine
// no dependencies; used by ise_cell and insertion_sort_engine
package ise_pkg;

   // per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;   // place the broadcast value
      logic drain;    // shift one place towards cell 0
   } cell_ctrl_type;

endpackage

// ----- sv/insertion_sort_engine.sv -----
// top level of the insertion sort engine: chain of ise_cell instances plus drain control
// depends on ise_pkg, ise_cell and insertion_sort_engine_macros.svh
//
// streaming insertion sorter. each word presented with start high while busy is low is inserted
// into an ascending chain of DEPTH cells; every cell compares its value with the broadcast word
// at once and the larger values step one cell right, so equal values keep their arrival order.
// a word marked with req_last is inserted as well and then the set is read out: busy rises and
// the chain shifts towards cell 0 once a cycle, giving one result per cycle with rsp_strobe
// high, lowest value first. rsp_last_res marks the greatest value, after which busy falls and
// the next set may start at once. the receiver cannot stall: results must be taken in the cycle
// they appear. words that arrive when all DEPTH cells are full are discarded, and rsp_dropped
// is then high on every result of that set. storage is cleared by reset only through the
// valid bits.
`include "insertion_sort_engine_macros.svh"
module insertion_sort_engine import ise_pkg::*; #(
   parameter int DEPTH       = 32,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic                          req_last,
   output logic                          rsp_strobe,
   output logic signed [VALUE_WIDTH-1:0] rsp_value_res,
   output logic                          rsp_last_res,
   output logic                          rsp_dropped
);

   // chain taps
   logic signed [VALUE_WIDTH-1:0] value_w [DEPTH];
   logic [DEPTH-1:0]              valid_w;
   logic [DEPTH-1:0]              gt_w;

   logic          drain_ff, drain_in;       // read-out in progress
   logic          overflow_ff, overflow_in; // a word of this set was dropped
   logic          accept;
   logic          full;
   logic          drain_done;
   cell_ctrl_type ctrl;

   assign accept     = start && !busy;
   assign full       = valid_w[DEPTH-1];
   // the word in cell 0 is the last one when cell 1 is already empty
   assign drain_done = drain_ff && !valid_w[1];

   assign ctrl.insert = accept && !full;
   assign ctrl.drain  = drain_ff;

   // the cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_WIDTH-1:0] left_value;
      logic                          left_valid;
      logic                          left_gt;
      logic signed [VALUE_WIDTH-1:0] right_value;
      logic                          right_valid;

      if (i == 0) begin : g_head
         // the head sees an always-full, never-greater neighbour
         assign left_value = '0;
         assign left_valid = 1'b1;
         assign left_gt    = 1'b0;
      end else begin : g_body
         assign left_value = value_w[i-1];
         assign left_valid = valid_w[i-1];
         assign left_gt    = gt_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         // nothing to the right: the tail empties while draining
         assign right_value = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner
         assign right_value = value_w[i+1];
         assign right_valid = valid_w[i+1];
      end

      ise_cell #(
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_value   (req_value),
         .left_value  (left_value),
         .left_valid  (left_valid),
         .left_gt     (left_gt),
         .right_value (right_value),
         .right_valid (right_valid),
         .value       (value_w[i]),
         .valid       (valid_w[i]),
         .gt          (gt_w[i])
      );
   end

   // drain and overflow control
   always_comb begin
      drain_in    = drain_ff;
      overflow_in = overflow_ff;
      priority if (drain_done) begin
         // set is out: clear for the next one
         drain_in    = 1'b0;
         overflow_in = 1'b0;
      end else if (accept) begin
         if (full) begin
            overflow_in = 1'b1;
         end
         if (req_last) begin
            drain_in = 1'b1;
         end
      end else begin
         // idle or mid read-out: hold
         drain_in    = drain_ff;
         overflow_in = overflow_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff    <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         drain_ff    <= drain_in;
         overflow_ff <= overflow_in;
      end
   end

   // the result value comes straight off the head cell; strobe, last and dropped from the drain control
   assign busy          = drain_ff;
   assign rsp_strobe    = drain_ff;
   assign rsp_value_res = value_w[0];
   assign rsp_last_res  = drain_done;
   assign rsp_dropped   = overflow_ff;

   // checks
   `ISE_ASSERT_IMPL(a_strobe_has_data, clock, reset, !rsp_strobe || valid_w[0])
   `ISE_ASSERT_IMPL(a_valid_contiguous, clock, reset,
      ((({1'b0, valid_w}) + {{DEPTH{1'b0}}, 1'b1}) & {1'b0, valid_w}) == '0)
   `ISE_ASSERT_NEXT(a_idle_after_final, clock, reset, rsp_strobe && rsp_last_res, !busy && !rsp_dropped)
   `ISE_ASSERT_NEXT(a_plain_word_no_busy, clock, reset, accept && !req_last, !busy)

endmodule

// ----- sv/ise_cell.sv -----
// one cell of the insertion chain: holds one value and its valid bit
// depends on ise_pkg
module ise_cell import ise_pkg::*; #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cell_ctrl_type                 ctrl,
   input  logic signed [VALUE_WIDTH-1:0] new_value,
   input  logic signed [VALUE_WIDTH-1:0] left_value,
   input  logic                          left_valid,
   input  logic                          left_gt,
   input  logic signed [VALUE_WIDTH-1:0] right_value,
   input  logic                          right_valid,
   output logic signed [VALUE_WIDTH-1:0] value,
   output logic                          valid,
   output logic                          gt
);

   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                          valid_ff, valid_in;
   logic                          first_empty;

   assign gt          = valid_ff && (value_ff > new_value);
   assign first_empty = !valid_ff && left_valid;
   assign value       = value_ff;
   assign valid       = valid_ff;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      priority if (ctrl.drain) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (ctrl.insert && (gt || first_empty)) begin
         // larger values move right; the gap takes the new value
         value_in = left_gt ? left_value : new_value;
         valid_in = 1'b1;
      end else begin
         // hold
         value_in = value_ff;
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// ----- verif/insertion_sort_engine_test.sv -----
// self-checking testbench for insertion_sort_engine: directed and random data sets
// depends only on the rtl of insertion_sort_engine; holds its own sorting predictor
module insertion_sort_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = 32;
   localparam int VALUE_WIDTH  = 16;
   localparam int WORDS_WANTED = 205;    // total words, directed ones included
   localparam int LIMIT_CYCLES = 200000;
   localparam int REPORT_MAX   = 10;

   typedef logic signed [VALUE_WIDTH-1:0] sample_type;

   // one expected output word
   typedef struct {
      sample_type value;
      logic       last;
      logic       dropped;
   } sorted_word_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   sample_type req_value;
   logic       req_last;
   logic       rsp_strobe;
   sample_type rsp_value_res;
   logic       rsp_last_res;
   logic       rsp_dropped;

   // predictor state: the set collected so far, kept in ascending order
   sample_type      held_values[DEPTH];
   int              held_count;
   logic            held_overflow;
   sorted_word_type sorted_due[$];

   int              words_sent;
   int              mismatches;
   int              cycle_count = 0;
   sorted_word_type want;

   insertion_sort_engine #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .req_last      (req_last),
      .rsp_strobe    (rsp_strobe),
      .rsp_value_res (rsp_value_res),
      .rsp_last_res  (rsp_last_res),
      .rsp_dropped   (rsp_dropped)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // watchdog: a hung handshake or a missing result ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // insert one accepted word; a word marked last releases the whole sorted set
   task automatic sort_insert(input sample_type value, input logic last);
      int pos;
      sorted_word_type w;
      if (held_count >= DEPTH) begin
         // store full: the word is lost, the set is flagged
         held_overflow = 1'b1;
      end else begin
         pos = held_count;
         // strictly greater only, so a new word lands after its equals
         while (pos > 0 && held_values[pos-1] > value) begin
            held_values[pos] = held_values[pos-1];
            pos--;
         end
         held_values[pos] = value;
         held_count++;
      end
      if (last) begin
         for (int k = 0; k < held_count; k++) begin
            w.value   = held_values[k];
            w.last    = (k == held_count - 1);
            w.dropped = held_overflow;
            sorted_due.push_back(w);
         end
         held_count    = 0;
         held_overflow = 1'b0;
      end
   endtask

   // present one word and hold it until the block takes it, then leave start low for the gap asked
   task automatic push_word(input sample_type value, input logic last, input int gap);
      @(negedge clock);
      start     = 1'b1;
      req_value = value;
      req_last  = last;
      // busy as seen just before the edge decides acceptance
      do @(posedge clock); while (busy);
      sort_insert(value, last);
      words_sent++;
      if (gap > 0) begin
         @(negedge clock);
         start     = 1'b0;
         req_value = sample_type'($urandom);
         req_last  = 1'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // mostly back to back, sometimes a short pause, now and then a long one
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      else if (r < 93)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   // full range, the two extremes, and a narrow band that gives many ties
   function automatic sample_type pick_value();
      case ($urandom_range(0, 9))
         0: return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
         1: return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
         2, 3: return sample_type'($urandom_range(0, 6)) - sample_type'(3);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // check every output word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (sorted_due.size() == 0) begin
            note_mismatch($sformatf("unexpected word value %0d last %b dropped %b",
                                    rsp_value_res, rsp_last_res, rsp_dropped));
         end else begin
            want = sorted_due.pop_front();
            if (rsp_value_res !== want.value || rsp_last_res !== want.last ||
                rsp_dropped !== want.dropped)
               note_mismatch($sformatf(
                  "expected value %0d last %b dropped %b, got value %0d last %b dropped %b",
                  want.value, want.last, want.dropped,
                  rsp_value_res, rsp_last_res, rsp_dropped));
         end
      end
   end

   // sets of a single word, at both ends of the range and at zero
   task automatic test_single_word_sets();
      push_word({1'b1, {(VALUE_WIDTH-1){1'b0}}}, 1'b1, 0);
      push_word({1'b0, {(VALUE_WIDTH-1){1'b1}}}, 1'b1, 2);
      push_word(sample_type'(0), 1'b1, 0);
   endtask

   // extremes mixed with repeats, so equal words must keep together in order
   task automatic test_extremes_and_ties();
      sample_type seq[$];
      seq = '{sample_type'(32767), sample_type'(-32768), sample_type'(0), sample_type'(-1),
              sample_type'(1), sample_type'(0), sample_type'(32767), sample_type'(-32768),
              sample_type'(-1), sample_type'(5)};
      foreach (seq[i])
         push_word(seq[i], i == seq.size() - 1, 0);
      // a short tie-heavy set with a pause in the middle
      push_word(sample_type'(7), 1'b0, 0);
      push_word(sample_type'(7), 1'b0, 3);
      push_word(sample_type'(-7), 1'b0, 0);
      push_word(sample_type'(7), 1'b1, 1);
   endtask

   // exactly DEPTH words, descending, so every insert shifts the whole chain
   task automatic test_full_store();
      for (int i = 0; i < DEPTH; i++)
         push_word(sample_type'(1000 - 37 * i), i == DEPTH - 1, idle_gap());
   endtask

   // more words than cells: the extra ones, the last word included, are lost
   task automatic test_overflow();
      for (int i = 0; i < DEPTH + 3; i++)
         push_word(pick_value(), i == DEPTH + 2, idle_gap());
   endtask

   // small sets with no idling at all, so the next set presses on a draining block
   task automatic test_back_to_back_sets();
      int size;
      repeat (6) begin
         size = $urandom_range(1, 4);
         for (int i = 0; i < size; i++)
            push_word(pick_value(), i == size - 1, 0);
      end
   endtask

   // random sets, mostly small, now and then close to, at or over the size of the store
   task automatic test_random_sets();
      int size;
      while (words_sent < WORDS_WANTED) begin
         if ($urandom_range(0, 11) == 0)
            size = $urandom_range(DEPTH - 2, DEPTH + 4);
         else
            size = $urandom_range(1, 7);
         for (int i = 0; i < size; i++)
            push_word(pick_value(), i == size - 1, idle_gap());
      end
   endtask

   initial begin
      start         = 1'b0;
      req_value     = '0;
      req_last      = 1'b0;
      reset         = 1'b1;
      held_count    = 0;
      held_overflow = 1'b0;
      words_sent    = 0;
      mismatches    = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_single_word_sets();
      test_extremes_and_ties();
      test_full_store();
      test_overflow();
      test_back_to_back_sets();
      test_random_sets();

      @(negedge clock);
      start = 1'b0;
      wait (sorted_due.size() == 0);
      // keep watching after the last expected word; anything that still comes out is spurious
      repeat (DEPTH + 8) @(posedge clock);
      if (mismatches == 0 && sorted_due.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+sv
sv/ise_pkg.sv
sv/ise_cell.sv
sv/insertion_sort_engine.sv
verif/insertion_sort_engine_test.sv
